### design/dstq_pkg.sv
// Shared types and constants for the deadline sorted task queue.
`timescale 1ns / 1ps
package dstq_pkg;

   localparam int KEY_BITS  = 32;
   localparam int PTAG_BITS = 8;
   localparam int MODE_BITS = 2;
   localparam int STAT_BITS = 2;
   localparam int OCC_BITS  = 5;

   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_PEEK   = 2'd3;

   localparam logic [STAT_BITS-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL     = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_NOTFOUND = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_EV,
      ST_HEAD_EV,
      ST_SHIFT_RD,
      ST_SHIFT_EV,
      ST_SRCH_RD,
      ST_SRCH_EV
   } state_type;

   typedef struct packed {
      logic key_lt;
      logic tag_eq;
   } cmp_type;

endpackage

### design/deadline_sorted_task_queue.sv
// Top level: earliest-deadline-first sorted task queue with its sequencer.
`timescale 1ns / 1ps
// Entries sit in one RAM in ascending deadline order, head at address 0. A small
// sequencer moves one entry at a time through the RAM's single read port
// (registered read) and the shared compare unit. Insert walks from the tail
// shifting larger-or-equal deadlines up by one; pop shifts the rest down; remove
// searches from the head by tag, then shifts. Insert into a full queue and pop or
// peek on an empty one are answered from idle; else busy stays high meanwhile.
// Each item yields exactly one result, shown for one cycle under rsp_valid;
// the receiver cannot stall it. Occupancy is the entry count after the item.
module deadline_sorted_task_queue #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TAG_BITS    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dstq_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [dstq_pkg::PTAG_BITS-1:0]       req_entry_tag,
   input  logic [dstq_pkg::KEY_BITS-1:0]        req_entry_key,
   output logic                                 rsp_valid,
   output logic [dstq_pkg::STAT_BITS-1:0]       rsp_status,
   output logic [dstq_pkg::PTAG_BITS-1:0]       rsp_out_tag,
   output logic [dstq_pkg::KEY_BITS-1:0]        rsp_out_key,
   output logic [dstq_pkg::OCC_BITS-1:0]        rsp_occupancy
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = dstq_pkg::KEY_BITS + TAG_BITS;

   dstq_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dstq_pkg::STAT_BITS-1:0]   status_ff, status_in;
   logic [dstq_pkg::MODE_BITS-1:0]   mode_ff, mode_in;
   logic [TAG_BITS-1:0]              tag_ff, tag_in;
   logic [dstq_pkg::KEY_BITS-1:0]    key_ff, key_in;
   logic [TAG_BITS-1:0]              res_tag_ff, res_tag_in;
   logic [dstq_pkg::KEY_BITS-1:0]    res_key_ff, res_key_in;

   logic                             ram_we;
   logic [IW-1:0]                    ram_waddr;
   logic [EW-1:0]                    ram_wdata;
   logic [IW-1:0]                    ram_raddr;
   logic [EW-1:0]                    ram_rdata;
   logic [dstq_pkg::KEY_BITS-1:0]    d_key;
   logic [TAG_BITS-1:0]              d_tag;

   dstq_pkg::cmp_type                flags;
   logic [CW-1:0]                    idx_inc, idx_dec;

   logic [31:0]                      tag_wide;
   logic [31:0]                      cnt_wide;

   assign d_key = ram_rdata[TAG_BITS +: dstq_pkg::KEY_BITS];
   assign d_tag = ram_rdata[TAG_BITS-1:0];

   dstq_ram #(
      .WIDTH(EW),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dstq_alu #(
      .TAG_BITS(TAG_BITS),
      .CNT_BITS(CW)
   ) u_alu (
      .mem_key (d_key),
      .req_key (key_ff),
      .mem_tag (d_tag),
      .req_tag (tag_ff),
      .idx     (idx_ff),
      .flags   (flags),
      .idx_inc (idx_inc),
      .idx_dec (idx_dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dstq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      mode_ff    <= mode_in;
      tag_ff     <= tag_in;
      key_ff     <= key_in;
      res_tag_ff <= res_tag_in;
      res_key_ff <= res_key_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      mode_in      = mode_ff;
      tag_in       = tag_ff;
      key_in       = key_ff;
      res_tag_in   = res_tag_ff;
      res_key_in   = res_key_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[IW-1:0];
      ram_wdata    = {key_ff, tag_ff};
      ram_raddr    = '0;

      case (state_ff)
         dstq_pkg::ST_IDLE: begin
            if (start) begin
               mode_in    = req_mode;
               tag_in     = TAG_BITS'(req_entry_tag);
               key_in     = req_entry_key;
               res_tag_in = '0;
               res_key_in = '0;
               status_in  = dstq_pkg::STAT_OK;
               case (req_mode)
                  dstq_pkg::MODE_INSERT: begin
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        status_in    = dstq_pkg::STAT_FULL;
                        rsp_valid_in = 1'b1;
                     end else begin
                        idx_in   = count_ff;
                        state_in = dstq_pkg::ST_INS_RD;
                     end
                  end
                  dstq_pkg::MODE_POP, dstq_pkg::MODE_PEEK: begin
                     if (count_ff == '0) begin
                        status_in    = dstq_pkg::STAT_EMPTY;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = dstq_pkg::ST_HEAD_EV;
                     end
                  end
                  dstq_pkg::MODE_REMOVE: begin
                     idx_in   = '0;
                     state_in = dstq_pkg::ST_SRCH_RD;
                  end
                  default: begin
                     state_in = dstq_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         dstq_pkg::ST_INS_RD: begin
            if (idx_ff == '0) begin
               ram_we       = 1'b1;
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = dstq_pkg::ST_IDLE;
            end else begin
               ram_raddr = idx_dec[IW-1:0];
               state_in  = dstq_pkg::ST_INS_EV;
            end
         end
         dstq_pkg::ST_INS_EV: begin
            ram_we = 1'b1;
            if (!flags.key_lt) begin
               ram_wdata = ram_rdata;
               idx_in    = idx_dec;
               state_in  = dstq_pkg::ST_INS_RD;
            end else begin
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = dstq_pkg::ST_IDLE;
            end
         end
         dstq_pkg::ST_HEAD_EV: begin
            res_tag_in = d_tag;
            res_key_in = d_key;
            if (mode_ff == dstq_pkg::MODE_PEEK) begin
               rsp_valid_in = 1'b1;
               state_in     = dstq_pkg::ST_IDLE;
            end else begin
               idx_in   = '0;
               state_in = dstq_pkg::ST_SHIFT_RD;
            end
         end
         dstq_pkg::ST_SHIFT_RD: begin
            if (idx_inc >= count_ff) begin
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = dstq_pkg::ST_IDLE;
            end else begin
               ram_raddr = idx_inc[IW-1:0];
               state_in  = dstq_pkg::ST_SHIFT_EV;
            end
         end
         dstq_pkg::ST_SHIFT_EV: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_inc;
            state_in  = dstq_pkg::ST_SHIFT_RD;
         end
         dstq_pkg::ST_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               status_in    = dstq_pkg::STAT_NOTFOUND;
               rsp_valid_in = 1'b1;
               state_in     = dstq_pkg::ST_IDLE;
            end else begin
               ram_raddr = idx_ff[IW-1:0];
               state_in  = dstq_pkg::ST_SRCH_EV;
            end
         end
         dstq_pkg::ST_SRCH_EV: begin
            if (flags.tag_eq) begin
               res_tag_in = d_tag;
               res_key_in = d_key;
               state_in   = dstq_pkg::ST_SHIFT_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = dstq_pkg::ST_SRCH_RD;
            end
         end
         default: begin
            state_in = dstq_pkg::ST_IDLE;
         end
      endcase
   end

   assign tag_wide = 32'(res_tag_ff);
   assign cnt_wide = 32'(count_ff);

   assign busy          = (state_ff != dstq_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_tag   = tag_wide[dstq_pkg::PTAG_BITS-1:0];
   assign rsp_out_key   = res_key_ff;
   assign rsp_occupancy = cnt_wide[dstq_pkg::OCC_BITS-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_count_moves_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("entry count changed without a result");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == dstq_pkg::STAT_FULL)) |-> (count_ff == CW'(QUEUE_DEPTH)))
      else $error("full status with free room");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == dstq_pkg::STAT_EMPTY)) |-> (count_ff == '0))
      else $error("empty status with entries held");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != dstq_pkg::ST_IDLE))
      else $error("store written while idle");

endmodule

### design/dstq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dstq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dstq_alu.sv
// Shared compare and index step unit used by the queue sequencer.
`timescale 1ns / 1ps
module dstq_alu #(
   parameter int TAG_BITS = 8,
   parameter int CNT_BITS = 5
) (
   input  logic [dstq_pkg::KEY_BITS-1:0] mem_key,
   input  logic [dstq_pkg::KEY_BITS-1:0] req_key,
   input  logic [TAG_BITS-1:0]           mem_tag,
   input  logic [TAG_BITS-1:0]           req_tag,
   input  logic [CNT_BITS-1:0]           idx,
   output dstq_pkg::cmp_type             flags,
   output logic [CNT_BITS-1:0]           idx_inc,
   output logic [CNT_BITS-1:0]           idx_dec
);

   always_comb begin
      flags.key_lt = (mem_key < req_key);
      flags.tag_eq = (mem_tag == req_tag);
   end

   assign idx_inc = idx + CNT_BITS'(1);
   assign idx_dec = idx - CNT_BITS'(1);

endmodule

### test/tb_deadline_sorted_task_queue.sv
// Testbench for the deadline sorted task queue: directed and random items, self-checking.
`timescale 1ns / 1ps
module tb_deadline_sorted_task_queue;

   localparam int DEPTH = 16;

   typedef struct {
      logic [dstq_pkg::MODE_BITS-1:0] mode;
      logic [dstq_pkg::PTAG_BITS-1:0] tag;
      logic [dstq_pkg::KEY_BITS-1:0]  key;
      int                             idle;
   } task_item_type;

   typedef struct {
      logic [dstq_pkg::STAT_BITS-1:0] status;
      logic [dstq_pkg::PTAG_BITS-1:0] tag;
      logic [dstq_pkg::KEY_BITS-1:0]  key;
      logic [dstq_pkg::OCC_BITS-1:0]  occ;
   } reply_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [dstq_pkg::MODE_BITS-1:0] req_mode = dstq_pkg::MODE_PEEK;
   logic [dstq_pkg::PTAG_BITS-1:0] req_entry_tag = '0;
   logic [dstq_pkg::KEY_BITS-1:0]  req_entry_key = '0;
   logic                           rsp_valid;
   logic [dstq_pkg::STAT_BITS-1:0] rsp_status;
   logic [dstq_pkg::PTAG_BITS-1:0] rsp_out_tag;
   logic [dstq_pkg::KEY_BITS-1:0]  rsp_out_key;
   logic [dstq_pkg::OCC_BITS-1:0]  rsp_occupancy;

   task_item_type pending_tasks[$];
   reply_type     awaited_replies[$];
   int            error_count = 0;

   // shadow of the ready list, head at index 0
   logic [dstq_pkg::KEY_BITS-1:0]  list_key[DEPTH];
   logic [dstq_pkg::PTAG_BITS-1:0] list_tag[DEPTH];
   int                             list_count = 0;

   deadline_sorted_task_queue dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_entry_tag (req_entry_tag),
      .req_entry_key (req_entry_key),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_key   (rsp_out_key),
      .rsp_occupancy (rsp_occupancy)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic ready_list_apply(input logic [dstq_pkg::MODE_BITS-1:0] mode,
                                   input logic [dstq_pkg::PTAG_BITS-1:0] tag,
                                   input logic [dstq_pkg::KEY_BITS-1:0] key,
                                   output reply_type r);
      int pos;
      int i;
      r.status = dstq_pkg::STAT_OK;
      r.tag    = '0;
      r.key    = '0;
      if (mode == dstq_pkg::MODE_INSERT) begin
         if (list_count >= DEPTH) begin
            r.status = dstq_pkg::STAT_FULL;
         end else begin
            pos = 0;
            while (pos < list_count && list_key[pos] < key) pos++;
            for (i = list_count; i > pos; i--) begin
               list_key[i] = list_key[i-1];
               list_tag[i] = list_tag[i-1];
            end
            list_key[pos] = key;
            list_tag[pos] = tag;
            list_count++;
         end
      end else if (mode == dstq_pkg::MODE_POP || mode == dstq_pkg::MODE_PEEK) begin
         if (list_count == 0) begin
            r.status = dstq_pkg::STAT_EMPTY;
         end else begin
            r.tag = list_tag[0];
            r.key = list_key[0];
            if (mode == dstq_pkg::MODE_POP) begin
               for (i = 0; i + 1 < list_count; i++) begin
                  list_key[i] = list_key[i+1];
                  list_tag[i] = list_tag[i+1];
               end
               list_count--;
            end
         end
      end else begin
         pos = 0;
         while (pos < list_count && list_tag[pos] != tag) pos++;
         if (pos == list_count) begin
            r.status = dstq_pkg::STAT_NOTFOUND;
         end else begin
            r.tag = list_tag[pos];
            r.key = list_key[pos];
            for (i = pos; i + 1 < list_count; i++) begin
               list_key[i] = list_key[i+1];
               list_tag[i] = list_tag[i+1];
            end
            list_count--;
         end
      end
      r.occ = list_count[dstq_pkg::OCC_BITS-1:0];
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < 100)
         $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic present(input task_item_type t);
      start         <= 1'b1;
      req_mode      <= t.mode;
      req_entry_tag <= t.tag;
      req_entry_key <= t.key;
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            pending_tasks.delete(0);
            if (pending_tasks.size() != 0 && $urandom_range(99) >= pending_tasks[0].idle)
               present(pending_tasks[0]);
            else
               start <= 1'b0;
         end else if (!start && pending_tasks.size() != 0 &&
                      $urandom_range(99) >= pending_tasks[0].idle) begin
            present(pending_tasks[0]);
         end
      end
   end

   // monitor: predicts on acceptance, then checks any result in the same cycle
   always @(posedge clock) begin
      reply_type r;
      reply_type want;
      if (!reset) begin
         if (start && !busy) begin
            ready_list_apply(req_mode, req_entry_tag, req_entry_key, r);
            awaited_replies.push_back(r);
         end
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("unexpected result, status", rsp_status, 0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_out_tag !== want.tag)
                  report_mismatch("out_tag", rsp_out_tag, want.tag);
               if (rsp_out_key !== want.key)
                  report_mismatch("out_key", rsp_out_key, want.key);
               if (rsp_occupancy !== want.occ)
                  report_mismatch("occupancy", rsp_occupancy, want.occ);
            end
         end
      end
   end

   function automatic task_item_type make_item(logic [dstq_pkg::MODE_BITS-1:0] mode,
                                               logic [dstq_pkg::PTAG_BITS-1:0] tag,
                                               logic [dstq_pkg::KEY_BITS-1:0] key,
                                               int idle);
      task_item_type t;
      t.mode = mode;
      t.tag  = tag;
      t.key  = key;
      t.idle = idle;
      return t;
   endfunction

   function automatic logic [dstq_pkg::KEY_BITS-1:0] random_deadline();
      int k;
      k = $urandom_range(99);
      if (k < 40) return dstq_pkg::KEY_BITS'($urandom_range(15));
      if (k < 45) return '0;
      if (k < 50) return '1;
      return dstq_pkg::KEY_BITS'($urandom);
   endfunction

   function automatic logic [dstq_pkg::PTAG_BITS-1:0] random_tag();
      if ($urandom_range(99) < 80) return dstq_pkg::PTAG_BITS'($urandom_range(15));
      return dstq_pkg::PTAG_BITS'($urandom_range(255));
   endfunction

   initial begin
      int i;
      int k;
      int idle;
      bit filling;
      logic [dstq_pkg::MODE_BITS-1:0] mode;
      int phase_idle[4] = '{0, 52, 23, 0};

      // empty queue cases
      pending_tasks.push_back(make_item(dstq_pkg::MODE_POP, 8'h00, 32'h0, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_PEEK, 8'hFF, 32'hFFFFFFFF, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_REMOVE, 8'h00, 32'h0, 0));
      // fill to capacity: extremes, equal deadlines, duplicate tags
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'h00, 32'h00000000, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'hFF, 32'hFFFFFFFF, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'h01, 32'h00000000, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'h05, 32'd10, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'h05, 32'd20, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'hAA, 32'hAAAAAAAA, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'h55, 32'h55555555, 0));
      for (i = 0; i < 9; i++)
         pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT,
                                           dstq_pkg::PTAG_BITS'(16 + i),
                                           dstq_pkg::KEY_BITS'(100 * i), 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_INSERT, 8'h33, 32'h1, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_PEEK, 8'h00, 32'h0, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_REMOVE, 8'h05, 32'h0, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_REMOVE, 8'h4D, 32'h0, 0));
      pending_tasks.push_back(make_item(dstq_pkg::MODE_POP, 8'h00, 32'h0, 0));

      // random: alternate filling and draining stretches so full and empty recur
      filling = 1'b1;
      for (i = 0; i < 1400; i++) begin
         if (i % 40 == 0) filling = (i % 80 == 0);
         idle = phase_idle[i * 4 / 1400];
         k = $urandom_range(99);
         if (filling)
            mode = (k < 70) ? dstq_pkg::MODE_INSERT : (k < 80) ? dstq_pkg::MODE_POP :
                   (k < 92) ? dstq_pkg::MODE_REMOVE : dstq_pkg::MODE_PEEK;
         else
            mode = (k < 25) ? dstq_pkg::MODE_INSERT : (k < 60) ? dstq_pkg::MODE_POP :
                   (k < 85) ? dstq_pkg::MODE_REMOVE : dstq_pkg::MODE_PEEK;
         pending_tasks.push_back(make_item(mode, random_tag(), random_deadline(), idle));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_tasks.size() != 0 || awaited_replies.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
